[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They use the i_clk clock and the
// i_rst_n active-low reset of the module that expands them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SOC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SOC_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[rtl/soc_pkg.sv]
// ----------------------------------------------------------------------------
// soc_pkg
// Types, sizes and codes shared by the strong orientation checker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package soc_pkg;

    // Capacity of the graph stores.
    localparam int MAX_VERTICES = 128;
    localparam int MAX_EDGES    = 1024;

    // Derived sizes.
    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int SLOTS = 2 * MAX_EDGES;
    localparam int SW    = $clog2(SLOTS);
    localparam int EW    = $clog2(MAX_EDGES + 1);
    localparam int SPW   = $clog2(MAX_VERTICES + 1);
    localparam int PW    = 2 * VW + 1;

    // Field widths of the words.
    localparam int CNT_W = 11;
    localparam int VTX_W = 8;

    // Actions of an input word.
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_COMPUTE = 2'd1;
    localparam logic [1:0] ACT_FETCH   = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    // Kinds of a result word.
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_EDGE    = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    // Mode that allows fetching.
    localparam logic [1:0] MODE_FETCH = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_VCOUNT = 1'b1;

    typedef struct packed {
        logic [1:0]       action;
        logic [VTX_W-1:0] end_a;
        logic [VTX_W-1:0] end_b;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       kind;
        logic             strongly_connected;
        logic [VTX_W-1:0] vertices_out;
        logic [CNT_W-1:0] edges_out;
        logic [VTX_W-1:0] tail;
        logic [VTX_W-1:0] head;
        logic             last;
    } t_out_word;

    // One frame of the depth-first walk.
    typedef struct packed {
        logic [VW-1:0] vert;
        logic [SW-1:0] cur;
        logic          more;
    } t_frame;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_LD_A, ST_LD_B, ST_LD_C, ST_LD_D, ST_ERR,
        ST_C_START, ST_CLR, ST_O_INIT, ST_O_OPEN, ST_O_CHK, ST_O_RD, ST_O_EV,
        ST_O_HEAD, ST_O_PUSH, ST_O_POPRD, ST_O_POPLD, ST_R_INIT, ST_R_RD,
        ST_R_ACC, ST_VERDICT, ST_F_START, ST_F_RD, ST_F_SCAN, ST_EMIT
    } t_ctrl_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_LATCH, OP_LD_A, OP_LD_B, OP_LD_C, OP_LD_D, OP_ERR,
        OP_C_START, OP_CLR, OP_O_INIT, OP_O_OPEN, OP_O_RD, OP_O_EV,
        OP_O_HEAD, OP_O_PUSH, OP_O_POPRD, OP_O_POPLD, OP_R_INIT, OP_R_RD,
        OP_R_ACC, OP_VERDICT, OP_F_START, OP_F_RD, OP_F_SCAN, OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       load_ok;
        logic       fetch_ok;
        logic       clr_last;
        logic       top_more;
        logic       sp_one;
        logic       push;
        logic       pass_end;
        logic       changed;
        logic       scan_finish;
        logic       row_end;
        logic       out_free;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/strong_orientation_checker.sv]
// ----------------------------------------------------------------------------
// strong_orientation_checker
// Top level: configuration registers on an APB-style port, the sequencer
// and the datapath of the strong orientation checker.
// ----------------------------------------------------------------------------
// Usage. Input words arrive on i_in_valid / o_in_ready / i_in_word and each
// gives exactly one result word on o_out_valid / i_out_ready / o_out_word.
// A load word appends an undirected edge, passing from acceptance through
// the dispatch state, the load states A to D and the emit state to the output
// register; a refused word goes through dispatch, the error state and emit.
// A compute word clears the 128-row orientation matrix row by row, walks
// depth first (a read and a check per listed edge slot, more steps for each
// stack push and each pop), then runs the forward and backward reachability
// together in passes over all vertices until a pass adds nothing. A fetch
// word scans the matrix one bit per cycle from the cursor, plus one row read
// every 128 bits, past the returned edge to the next set bit, so its time
// follows the gap between oriented edges. One word is in work at a time;
// the next one is accepted as soon as the result is in the output register,
// even while the receiver stalls. A stalled result holds its word until
// taken. Reset empties the lists, clears counts, the verdict and the cursor,
// and restores mode 1 and vertex count 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module strong_orientation_checker
    import soc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_word    i_in_word,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_word        o_out_word,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [1:0] r_mode;
    logic [7:0] r_vcount;
    logic       w_reg_sel;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign pready    = 1'b1;
    assign w_reg_sel = paddr[2];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 2'd1;
            r_vcount <= 8'd1;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg_sel)
                REG_MODE:   r_mode   <= pwdata[1:0];
                REG_VCOUNT: r_vcount <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (w_reg_sel)
            REG_MODE:   prdata = {30'd0, r_mode};
            REG_VCOUNT: prdata = {24'd0, r_vcount};
            default:    prdata = '0;
        endcase
    end

    soc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    soc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_word   (i_in_word),
        .i_mode      (r_mode),
        .i_vcount    (r_vcount),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

[rtl/soc_ctrl.sv]
// ----------------------------------------------------------------------------
// soc_ctrl
// Sequencer of the checker: steps the datapath through loads, the
// orientation walk, the reachability passes and the fetch scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module soc_ctrl
    import soc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath command.
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NOP;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_status.action)
                    ACT_LOAD:    n_state = i_status.load_ok ? ST_LD_A : ST_ERR;
                    ACT_COMPUTE: n_state = ST_C_START;
                    ACT_FETCH:   n_state = i_status.fetch_ok ? ST_F_START : ST_ERR;
                    default:     n_state = ST_ERR;
                endcase
            end
            ST_LD_A: begin
                o_cmd.op = OP_LD_A;
                n_state  = ST_LD_B;
            end
            ST_LD_B: begin
                o_cmd.op = OP_LD_B;
                n_state  = ST_LD_C;
            end
            ST_LD_C: begin
                o_cmd.op = OP_LD_C;
                n_state  = ST_LD_D;
            end
            ST_LD_D: begin
                o_cmd.op = OP_LD_D;
                n_state  = ST_EMIT;
            end
            ST_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = ST_EMIT;
            end
            ST_C_START: begin
                o_cmd.op = OP_C_START;
                n_state  = ST_CLR;
            end
            ST_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_status.clr_last) begin
                    n_state = ST_O_INIT;
                end
            end
            ST_O_INIT: begin
                o_cmd.op = OP_O_INIT;
                n_state  = ST_O_OPEN;
            end
            ST_O_OPEN: begin
                o_cmd.op = OP_O_OPEN;
                n_state  = ST_O_CHK;
            end
            ST_O_CHK: begin
                if (i_status.top_more) begin
                    n_state = ST_O_RD;
                end else if (i_status.sp_one) begin
                    n_state = ST_R_INIT;
                end else begin
                    n_state = ST_O_POPRD;
                end
            end
            ST_O_RD: begin
                o_cmd.op = OP_O_RD;
                n_state  = ST_O_EV;
            end
            ST_O_EV: begin
                o_cmd.op = OP_O_EV;
                n_state  = i_status.push ? ST_O_HEAD : ST_O_CHK;
            end
            ST_O_HEAD: begin
                o_cmd.op = OP_O_HEAD;
                n_state  = ST_O_PUSH;
            end
            ST_O_PUSH: begin
                o_cmd.op = OP_O_PUSH;
                n_state  = ST_O_CHK;
            end
            ST_O_POPRD: begin
                o_cmd.op = OP_O_POPRD;
                n_state  = ST_O_POPLD;
            end
            ST_O_POPLD: begin
                o_cmd.op = OP_O_POPLD;
                n_state  = ST_O_CHK;
            end
            ST_R_INIT: begin
                o_cmd.op = OP_R_INIT;
                n_state  = ST_R_RD;
            end
            ST_R_RD: begin
                o_cmd.op = OP_R_RD;
                n_state  = ST_R_ACC;
            end
            ST_R_ACC: begin
                o_cmd.op = OP_R_ACC;
                if (!i_status.pass_end || i_status.changed) begin
                    n_state = ST_R_RD;
                end else begin
                    n_state = ST_VERDICT;
                end
            end
            ST_VERDICT: begin
                o_cmd.op = OP_VERDICT;
                n_state  = ST_EMIT;
            end
            ST_F_START: begin
                o_cmd.op = OP_F_START;
                n_state  = ST_F_RD;
            end
            ST_F_RD: begin
                o_cmd.op = OP_F_RD;
                n_state  = ST_F_SCAN;
            end
            ST_F_SCAN: begin
                o_cmd.op = OP_F_SCAN;
                if (i_status.scan_finish) begin
                    n_state = ST_EMIT;
                end else if (i_status.row_end) begin
                    n_state = ST_F_RD;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[rtl/soc_datapath.sv]
// ----------------------------------------------------------------------------
// soc_datapath
// Adjacency stores, orientation matrix, walk stack, reachability sets,
// fetch cursor and the output register, driven one command per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module soc_datapath
    import soc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    input  wire t_in_word   i_in_word,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_vcount,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_word       o_out_word
);

    // Memories.
    logic [VW-1:0]           r_nb_mem    [SLOTS];
    logic [SW-1:0]           r_next_mem  [SLOTS];
    logic [SW-1:0]           r_head_mem  [MAX_VERTICES];
    logic [SW-1:0]           r_tail_mem  [MAX_VERTICES];
    t_frame                  r_stack_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_fmat      [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_tmat      [MAX_VERTICES];

    // Registered read data.
    logic [VW-1:0]           r_nb_rd;
    logic [SW-1:0]           r_next_rd;
    logic [SW-1:0]           r_head_rd;
    logic [SW-1:0]           r_tail_rd;
    t_frame                  r_stack_rd;
    logic [MAX_VERTICES-1:0] r_frow;
    logic [MAX_VERTICES-1:0] r_trow;

    // Control state.
    logic [MAX_VERTICES-1:0] r_ne;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_fseen;
    logic [MAX_VERTICES-1:0] r_bseen;
    logic [EW-1:0]           r_edges;
    logic                    r_verdict;
    logic [PW-1:0]           r_cursor;
    logic [SPW-1:0]          r_sp;
    logic [VW-1:0]           r_cnt;
    logic                    r_changed;
    logic                    r_phase;
    logic                    r_out_valid;

    // Payload registers.
    t_in_word                r_in;
    t_frame                  r_top;
    logic [VW-1:0]           r_w;
    logic [PW-1:0]           r_p;
    logic [PW-2:0]           r_c;
    t_out_word               r_res;
    t_out_word               r_out_word;

    // Combinational helpers.
    logic [8:0]              w_n;
    logic [7:0]              w_am1;
    logic [7:0]              w_bm1;
    logic [VW-1:0]           w_a_idx;
    logic [VW-1:0]           w_b_idx;
    logic [SW-1:0]           w_slot_a;
    logic [SW-1:0]           w_slot_b;
    logic [EW-1:0]           w_edges_inc;
    logic                    w_load_ok;
    logic [VW-1:0]           w_tail_raddr;
    logic [VW-1:0]           w_head_raddr;
    logic [VW-1:0]           w_fmat_raddr;
    logic [VW-1:0]           w_tmat_raddr;
    logic                    w_frow_en;
    logic [VW-1:0]           w_u;
    logic [VW-1:0]           w_w;
    logic                    w_hit;
    logic                    w_push;
    logic [SPW-1:0]          w_sp_m1;
    logic [SPW-1:0]          w_sp_m2;
    logic [MAX_VERTICES-1:0] w_fnext;
    logic [MAX_VERTICES-1:0] w_bnext;
    logic                    w_changed;
    logic [MAX_VERTICES-1:0] w_mask;
    logic                    w_ok;
    logic                    w_bit;
    logic                    w_p_end;
    logic [8:0]              w_tail9;
    logic [8:0]              w_head9;
    logic [PW-1:0]           w_c_inc;

    // Effective vertex count: zero acts as one, large values saturate.
    always_comb begin
        if (i_vcount == 8'd0) begin
            w_n = 9'd1;
        end else if ({1'b0, i_vcount} > 9'(MAX_VERTICES)) begin
            w_n = 9'(MAX_VERTICES);
        end else begin
            w_n = {1'b0, i_vcount};
        end
    end

    // Endpoint indexes, slots and the load check.
    assign w_am1       = r_in.end_a - 8'd1;
    assign w_bm1       = r_in.end_b - 8'd1;
    assign w_a_idx     = w_am1[VW-1:0];
    assign w_b_idx     = w_bm1[VW-1:0];
    assign w_slot_a    = SW'({r_edges, 1'b0});
    assign w_slot_b    = SW'({r_edges, 1'b1});
    assign w_edges_inc = r_edges + EW'(1);
    assign w_load_ok   = (r_in.end_a != 8'd0) && ({1'b0, r_in.end_a} <= w_n) &&
                         (r_in.end_b != 8'd0) && ({1'b0, r_in.end_b} <= w_n) &&
                         (r_edges < EW'(MAX_EDGES));

    // Read address selection.
    always_comb begin
        case (i_cmd.op)
            OP_LD_A: w_tail_raddr = w_a_idx;
            OP_LD_C: w_tail_raddr = w_b_idx;
            default: w_tail_raddr = r_top.vert;
        endcase
        case (i_cmd.op)
            OP_O_HEAD: w_head_raddr = r_w;
            default:   w_head_raddr = '0;
        endcase
        case (i_cmd.op)
            OP_O_RD: w_fmat_raddr = r_top.vert;
            OP_R_RD: w_fmat_raddr = r_cnt;
            default: w_fmat_raddr = r_p[PW-2:VW];
        endcase
        case (i_cmd.op)
            OP_O_RD: w_tmat_raddr = r_top.vert;
            default: w_tmat_raddr = r_cnt;
        endcase
        w_frow_en = (i_cmd.op == OP_O_RD) || (i_cmd.op == OP_R_RD) ||
                    (i_cmd.op == OP_F_RD);
    end

    // Orientation step: the far vertex and whether the edge is taken.
    assign w_u     = r_top.vert;
    assign w_w     = r_nb_rd;
    assign w_hit   = r_frow[w_w] | r_trow[w_w];
    assign w_push  = !w_hit && !r_visited[w_w] && (r_sp < SPW'(MAX_VERTICES));
    assign w_sp_m1 = r_sp - SPW'(1);
    assign w_sp_m2 = r_sp - SPW'(2);

    // Reachability pass: merge the row of a reached vertex.
    assign w_fnext   = r_fseen | (r_fseen[r_cnt] ? r_frow : '0);
    assign w_bnext   = r_bseen | (r_bseen[r_cnt] ? r_trow : '0);
    assign w_changed = r_changed || (w_fnext != r_fseen) || (w_bnext != r_bseen);

    // Verdict over vertices 1..n.
    always_comb begin
        for (int k = 0; k < MAX_VERTICES; k++) begin
            w_mask[k] = (9'(k) < w_n);
        end
    end
    assign w_ok = &((r_fseen & r_bseen) | ~w_mask);

    // Fetch scan helpers.
    assign w_bit   = r_frow[r_p[VW-1:0]];
    assign w_p_end = r_p[PW-1];
    assign w_tail9 = 9'(r_c[PW-2:VW]) + 9'd1;
    assign w_head9 = 9'(r_c[VW-1:0]) + 9'd1;
    assign w_c_inc = {1'b0, r_c} + PW'(1);

    // Status toward the controller.
    always_comb begin
        o_status.action      = r_in.action;
        o_status.load_ok     = w_load_ok;
        o_status.fetch_ok    = (i_mode == MODE_FETCH) && r_verdict;
        o_status.clr_last    = (r_cnt == VW'(MAX_VERTICES - 1));
        o_status.top_more    = r_top.more;
        o_status.sp_one      = (r_sp == SPW'(1));
        o_status.push        = w_push;
        o_status.pass_end    = (r_cnt == VW'(MAX_VERTICES - 1));
        o_status.changed     = w_changed;
        o_status.scan_finish = w_p_end || (w_bit && r_phase);
        o_status.row_end     = (r_p[VW-1:0] == VW'(MAX_VERTICES - 1));
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        r_tail_rd  <= r_tail_mem[w_tail_raddr];
        r_nb_rd    <= r_nb_mem[r_top.cur];
        r_next_rd  <= r_next_mem[r_top.cur];
        r_stack_rd <= r_stack_mem[w_sp_m2[VW-1:0]];
        if (i_cmd.op == OP_O_INIT || i_cmd.op == OP_O_HEAD) begin
            r_head_rd <= r_head_mem[w_head_raddr];
        end
        if (w_frow_en) begin
            r_frow <= r_fmat[w_fmat_raddr];
            r_trow <= r_tmat[w_tmat_raddr];
        end
        case (i_cmd.op)
            OP_LD_A: begin
                r_nb_mem[w_slot_a]   <= w_b_idx;
                r_next_mem[w_slot_a] <= '0;
            end
            OP_LD_B: begin
                if (r_ne[w_a_idx]) begin
                    r_next_mem[r_tail_rd] <= w_slot_a;
                end else begin
                    r_head_mem[w_a_idx] <= w_slot_a;
                end
                r_tail_mem[w_a_idx] <= w_slot_a;
            end
            OP_LD_C: begin
                r_nb_mem[w_slot_b]   <= w_a_idx;
                r_next_mem[w_slot_b] <= '0;
            end
            OP_LD_D: begin
                if (r_ne[w_b_idx]) begin
                    r_next_mem[r_tail_rd] <= w_slot_b;
                end else begin
                    r_head_mem[w_b_idx] <= w_slot_b;
                end
                r_tail_mem[w_b_idx] <= w_slot_b;
            end
            OP_CLR: begin
                r_fmat[r_cnt] <= '0;
                r_tmat[r_cnt] <= '0;
            end
            OP_O_EV: begin
                if (!w_hit) begin
                    r_fmat[w_u][w_w] <= 1'b1;
                    r_tmat[w_w][w_u] <= 1'b1;
                end
            end
            OP_O_PUSH: begin
                r_stack_mem[w_sp_m1[VW-1:0]] <= r_top;
            end
            default: ;
        endcase
    end

    // Control state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne        <= '0;
            r_visited   <= '0;
            r_fseen     <= '0;
            r_bseen     <= '0;
            r_edges     <= '0;
            r_verdict   <= 1'b0;
            r_cursor    <= '0;
            r_sp        <= '0;
            r_cnt       <= '0;
            r_changed   <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_LD_B: r_ne[w_a_idx] <= 1'b1;
                OP_LD_D: begin
                    r_ne[w_b_idx] <= 1'b1;
                    r_edges       <= w_edges_inc;
                    r_verdict     <= 1'b0;
                end
                OP_C_START: begin
                    r_visited <= '0;
                    r_fseen   <= '0;
                    r_bseen   <= '0;
                    r_cnt     <= '0;
                end
                OP_CLR:    r_cnt <= r_cnt + VW'(1);
                OP_O_INIT: r_visited[0] <= 1'b1;
                OP_O_OPEN: r_sp <= SPW'(1);
                OP_O_EV: begin
                    if (w_push) begin
                        r_visited[w_w] <= 1'b1;
                    end
                end
                OP_O_PUSH:  r_sp <= r_sp + SPW'(1);
                OP_O_POPRD: r_sp <= w_sp_m1;
                OP_R_INIT: begin
                    r_sp      <= '0;
                    r_fseen   <= MAX_VERTICES'(1);
                    r_bseen   <= MAX_VERTICES'(1);
                    r_cnt     <= '0;
                    r_changed <= 1'b0;
                end
                OP_R_ACC: begin
                    r_fseen   <= w_fnext;
                    r_bseen   <= w_bnext;
                    r_cnt     <= r_cnt + VW'(1);
                    r_changed <= o_status.pass_end ? 1'b0 : w_changed;
                end
                OP_VERDICT: begin
                    r_verdict <= w_ok;
                    r_cursor  <= '0;
                end
                OP_F_START: r_phase <= 1'b0;
                OP_F_SCAN: begin
                    if (w_p_end) begin
                        r_cursor <= r_phase ? w_c_inc : r_p;
                    end else if (w_bit) begin
                        if (r_phase) begin
                            r_cursor <= w_c_inc;
                        end else begin
                            r_phase <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload updates: input word, walk frame, scan pointer and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_out_word <= r_res;
        end
        case (i_cmd.op)
            OP_LATCH: r_in <= i_in_word;
            OP_LD_D: begin
                r_res           <= '0;
                r_res.kind      <= KIND_LOAD;
                r_res.edges_out <= CNT_W'(w_edges_inc);
            end
            OP_ERR: begin
                r_res      <= '0;
                r_res.kind <= KIND_NONE;
            end
            OP_O_OPEN: begin
                r_top.vert <= '0;
                r_top.cur  <= r_head_rd;
                r_top.more <= r_ne[0];
            end
            OP_O_EV: begin
                if (r_top.cur == r_tail_rd) begin
                    r_top.more <= 1'b0;
                end else begin
                    r_top.cur <= r_next_rd;
                end
                r_w <= w_w;
            end
            OP_O_PUSH: begin
                r_top.vert <= r_w;
                r_top.cur  <= r_head_rd;
                r_top.more <= r_ne[r_w];
            end
            OP_O_POPLD: r_top <= r_stack_rd;
            OP_VERDICT: begin
                r_res                    <= '0;
                r_res.kind               <= KIND_VERDICT;
                r_res.strongly_connected <= w_ok;
                r_res.vertices_out       <= w_n[7:0];
                r_res.edges_out          <= CNT_W'(r_edges);
            end
            OP_F_START: r_p <= r_cursor;
            OP_F_SCAN: begin
                if (w_p_end) begin
                    r_res <= '0;
                    if (r_phase) begin
                        r_res.kind <= KIND_EDGE;
                        r_res.tail <= w_tail9[7:0];
                        r_res.head <= w_head9[7:0];
                        r_res.last <= 1'b1;
                    end else begin
                        r_res.kind <= KIND_NONE;
                    end
                end else if (w_bit && r_phase) begin
                    r_res      <= '0;
                    r_res.kind <= KIND_EDGE;
                    r_res.tail <= w_tail9[7:0];
                    r_res.head <= w_head9[7:0];
                    r_res.last <= 1'b0;
                end else begin
                    if (w_bit) begin
                        r_c <= r_p[PW-2:0];
                    end
                    r_p <= r_p + PW'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Checks on the walk stack, the edge count and the output register.
    `SOC_ASSERT(a_sp_bound, r_sp <= SPW'(MAX_VERTICES), "walk stack overflow")
    `SOC_ASSERT_NEXT(a_push_grows, i_cmd.op == OP_O_PUSH, r_sp == $past(r_sp) + SPW'(1), "push did not grow the stack")
    `SOC_ASSERT(a_edges_bound, r_edges <= EW'(MAX_EDGES), "edge count beyond capacity")
    `SOC_ASSERT_NEXT(a_emit_valid, i_cmd.op == OP_EMIT, r_out_valid, "emitted word not valid")

endmodule

`default_nettype wire
